@@ hdl/buvg_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery undervoltage guard package
// Field widths, configuration register indexes and reset values that the
// guard block uses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package buvg_pkg;

	// ADC sample and threshold width.
	localparam int SAMPLE_W = 12;
	// Recovery countdown width.
	localparam int COUNT_W = 8;
	// Configuration data is as wide as the widest register.
	localparam int CFG_DATA_W = 12;
	localparam int CFG_INDEX_W = 2;

	// Default number of samples in one window.
	localparam int DEFAULT_WINDOW = 8;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LOW_THRESHOLD    = 2'd0,
		REG_INSERT_THRESHOLD = 2'd1,
		REG_STABLE_SPAN      = 2'd2,
		REG_RECOVERY_COUNT   = 2'd3
	} cfg_reg_t;

	// Register values after reset.
	localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST    = 12'd2000;
	localparam logic [SAMPLE_W-1:0] INSERT_THRESHOLD_RST = 12'd2200;
	localparam logic [SAMPLE_W-1:0] STABLE_SPAN_RST      = 12'd32;
	localparam logic [COUNT_W-1:0]  RECOVERY_COUNT_RST   = 8'd20;

endpackage

`default_nettype wire

@@ hdl/battery_undervoltage_guard.sv @@
// ----------------------------------------------------------------------------
// Battery undervoltage guard
// Windowed battery voltage monitor with hysteresis between a trip threshold
// and a recovery threshold, and a countdown of stable good windows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Every request on the input channel carries one ADC sample and produces
// exactly one response. WINDOW requests fill a window (only the running sum,
// minimum and maximum are kept); the request after a full window ignores its
// sample and judges the window instead. The window average is the sum divided
// by WINDOW, done as a multiplication by a precomputed reciprocal. A window is
// stable when its maximum minus its minimum is below stable_span. An average
// below low_threshold reloads the recovery countdown and, when stable, trips a
// healthy battery into error. In error, each stable window whose average is
// above insert_threshold decrements a nonzero countdown; reaching zero restores
// normal. An average equal to low_threshold changes nothing. The block takes
// one request per clock cycle: the whole update is one pass of logic from the
// state registers and the incoming sample into the response register, and a
// new request is accepted whenever the response register is empty or its
// response is being taken in the same cycle. A response therefore appears
// in the cycle after its request is accepted. Configuration writes take effect
// at once and are meant to be made while no request is in flight.
module battery_undervoltage_guard #(
	parameter int WINDOW = buvg_pkg::DEFAULT_WINDOW
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Configuration write port.
	input  wire logic                                  cfg_we,
	input  wire logic [buvg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [buvg_pkg::CFG_DATA_W-1:0]       cfg_data,
	// Sample requests.
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [buvg_pkg::SAMPLE_W-1:0]         sample,
	// Responses.
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       battery_ok,
	output logic                                       entered_error,
	output logic                                       entered_normal,
	output logic [buvg_pkg::SAMPLE_W-1:0]              window_average,
	output logic                                       evaluated
);

	// Window bookkeeping widths.
	localparam int LOG_W    = $clog2(WINDOW);
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int SUM_W    = buvg_pkg::SAMPLE_W + LOG_W;
	// Reciprocal for the division by WINDOW. With the shift chosen this way,
	// sum times the rounding error of the reciprocal stays below 2**DIV_SH,
	// so the truncated product is exactly floor(sum / WINDOW).
	localparam int DIV_SH   = SUM_W + LOG_W + 1;
	localparam int RECIP_W  = DIV_SH - LOG_W + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

	// Configuration registers.
	logic [buvg_pkg::SAMPLE_W-1:0] low_threshold_q;
	logic [buvg_pkg::SAMPLE_W-1:0] insert_threshold_q;
	logic [buvg_pkg::SAMPLE_W-1:0] stable_span_q;
	logic [buvg_pkg::COUNT_W-1:0]  recovery_count_q;

	// Window and guard state.
	logic [FILL_W-1:0]             fill_count_q;
	logic [SUM_W-1:0]              window_sum_q;
	logic [buvg_pkg::SAMPLE_W-1:0] window_min_q;
	logic [buvg_pkg::SAMPLE_W-1:0] window_max_q;
	logic                          in_error_q;
	logic [buvg_pkg::COUNT_W-1:0]  recovery_left_q;

	// Next-state and response values.
	logic                          accept;
	logic                          judge;
	logic [PROD_W-1:0]             avg_prod;
	logic [buvg_pkg::SAMPLE_W-1:0] avg;
	logic                          stable;
	logic                          in_error_d;
	logic [buvg_pkg::COUNT_W-1:0]  recovery_left_d;
	logic                          went_err;
	logic                          went_ok;
	logic [buvg_pkg::COUNT_W-1:0]  recovery_dec;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;
	assign judge    = (fill_count_q >= FILL_FULL);

	// Only meaningful on a judging request, when the window holds WINDOW
	// samples and so the maximum is never below the minimum.
	assign avg_prod     = PROD_W'(window_sum_q) * PROD_W'(RECIP);
	assign avg          = avg_prod[DIV_SH +: buvg_pkg::SAMPLE_W];
	assign stable       = (window_max_q - window_min_q) < stable_span_q;
	assign recovery_dec = recovery_left_q - buvg_pkg::COUNT_W'(1);

	always_comb begin
		in_error_d      = in_error_q;
		recovery_left_d = recovery_left_q;
		went_err        = 1'b0;
		went_ok         = 1'b0;
		if (judge) begin
			if (avg < low_threshold_q) begin
				// A low window always reloads the countdown; only a stable
				// one trips the battery.
				recovery_left_d = recovery_count_q;
				if (!in_error_q && stable) begin
					in_error_d = 1'b1;
					went_err   = 1'b1;
				end
			end else if (avg > low_threshold_q) begin
				if (in_error_q && (avg > insert_threshold_q) && stable
						&& (recovery_left_q != '0)) begin
					recovery_left_d = recovery_dec;
					if (recovery_dec == '0) begin
						in_error_d = 1'b0;
						went_ok    = 1'b1;
					end
				end
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_threshold_q    <= buvg_pkg::LOW_THRESHOLD_RST;
			insert_threshold_q <= buvg_pkg::INSERT_THRESHOLD_RST;
			stable_span_q      <= buvg_pkg::STABLE_SPAN_RST;
			recovery_count_q   <= buvg_pkg::RECOVERY_COUNT_RST;
		end else if (cfg_we) begin
			unique case (buvg_pkg::cfg_reg_t'(cfg_index))
				buvg_pkg::REG_LOW_THRESHOLD: begin
					low_threshold_q <= cfg_data;
				end
				buvg_pkg::REG_INSERT_THRESHOLD: begin
					insert_threshold_q <= cfg_data;
				end
				buvg_pkg::REG_STABLE_SPAN: begin
					stable_span_q <= cfg_data;
				end
				buvg_pkg::REG_RECOVERY_COUNT: begin
					recovery_count_q <= cfg_data[buvg_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q    <= '0;
			in_error_q      <= 1'b0;
			recovery_left_q <= '0;
			out_valid       <= 1'b0;
		end else begin
			if (accept) begin
				in_error_q      <= in_error_d;
				recovery_left_q <= recovery_left_d;
				if (judge) begin
					fill_count_q <= '0;
				end else begin
					fill_count_q <= fill_count_q + FILL_W'(1);
				end
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Window accumulators and response payload. The accumulators are
	// overwritten by the first sample of every window, so they need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!judge) begin
				if (fill_count_q == '0) begin
					window_sum_q <= SUM_W'(sample);
					window_min_q <= sample;
					window_max_q <= sample;
				end else begin
					window_sum_q <= window_sum_q + SUM_W'(sample);
					if (sample < window_min_q) begin
						window_min_q <= sample;
					end
					if (sample > window_max_q) begin
						window_max_q <= sample;
					end
				end
			end
			battery_ok     <= !in_error_d;
			entered_error  <= went_err;
			entered_normal <= went_ok;
			window_average <= judge ? avg : '0;
			evaluated      <= judge;
		end
	end

`ifndef SYNTHESIS
	// The window fill never runs past WINDOW samples.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= FILL_FULL)
		else $error("window fill count beyond window size");

	// A state change is reported only by a judging response and matches
	// the reported battery state.
	a_err_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && entered_error) |-> (evaluated && !battery_ok && !entered_normal))
		else $error("entered_error without a judged window or with battery ok");

	a_ok_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && entered_normal) |-> (evaluated && battery_ok))
		else $error("entered_normal without a judged window or with battery in error");

	// A collecting response carries no average.
	a_collect_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !evaluated) |-> (window_average == '0))
		else $error("nonzero average on a collecting response");

	// The request after a full window is always a judging one.
	a_judge_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (fill_count_q == FILL_FULL)) |=> (out_valid && evaluated))
		else $error("full window not judged by the next request");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Battery undervoltage guard testbench
// Drives ADC sample requests through the guard and checks every response
// against a cycle-free model of the windowed trip and recovery logic. A short
// table of hand-checked requests comes first. Random windows follow under
// several register settings and with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import buvg_pkg::*;

	localparam int SW = SAMPLE_W;
	localparam int WIN = DEFAULT_WINDOW;
	localparam int SUM_W = SW + $clog2(WIN);
	localparam int FILL_W = $clog2(WIN + 1);
	localparam int PHASE_ITEMS = 215;
	localparam int WATCHDOG_LIMIT = 1000;

	// One response of the guard, field by field.
	typedef struct packed {
		logic          battery_ok;
		logic          entered_error;
		logic          entered_normal;
		logic [SW-1:0] window_average;
		logic          evaluated;
	} guard_resp_t;

	// One request as issued: the sample, and the response typed in by hand
	// when the row carries one.
	typedef struct packed {
		logic [SW-1:0] adc;
		logic          typed;
		guard_resp_t   resp;
	} sample_row_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum {PLAN_BELOW, PLAN_EQUAL, PLAN_BETWEEN, PLAN_ABOVE, PLAN_NOISE} window_plan_t;

	localparam guard_resp_t COLLECT_OK = '{1'b1, 1'b0, 1'b0, 12'd0, 1'b0};
	localparam guard_resp_t COLLECT_ERR = '{1'b0, 1'b0, 1'b0, 12'd0, 1'b0};

	// Three windows on the reset register values. The first alternates the two
	// sample extremes: wide spread, average 2047, nothing happens. The second is
	// a flat low window that trips the battery into error. The third averages
	// exactly the low threshold with a narrow spread, which must change nothing.
	// The sample on each judging request is ignored by the block.
	localparam sample_row_t DIRECTED [27] = '{
		'{12'd0,    1'b1, COLLECT_OK}, '{12'd4095, 1'b1, COLLECT_OK},
		'{12'd0,    1'b1, COLLECT_OK}, '{12'd4095, 1'b1, COLLECT_OK},
		'{12'd0,    1'b1, COLLECT_OK}, '{12'd4095, 1'b1, COLLECT_OK},
		'{12'd0,    1'b1, COLLECT_OK}, '{12'd4095, 1'b1, COLLECT_OK},
		'{12'd4095, 1'b1, '{1'b1, 1'b0, 1'b0, 12'd2047, 1'b1}},
		'{12'd100,  1'b1, COLLECT_OK}, '{12'd100,  1'b1, COLLECT_OK},
		'{12'd100,  1'b1, COLLECT_OK}, '{12'd100,  1'b1, COLLECT_OK},
		'{12'd100,  1'b1, COLLECT_OK}, '{12'd100,  1'b1, COLLECT_OK},
		'{12'd100,  1'b1, COLLECT_OK}, '{12'd100,  1'b1, COLLECT_OK},
		'{12'd0,    1'b1, '{1'b0, 1'b1, 1'b0, 12'd100, 1'b1}},
		'{12'd1990, 1'b1, COLLECT_ERR}, '{12'd2010, 1'b1, COLLECT_ERR},
		'{12'd1990, 1'b1, COLLECT_ERR}, '{12'd2010, 1'b1, COLLECT_ERR},
		'{12'd1990, 1'b1, COLLECT_ERR}, '{12'd2010, 1'b1, COLLECT_ERR},
		'{12'd1990, 1'b1, COLLECT_ERR}, '{12'd2010, 1'b1, COLLECT_ERR},
		'{12'hAAA,  1'b1, '{1'b0, 1'b0, 1'b0, 12'd2000, 1'b1}}
	};

	// Every input has a known value from time zero; reset is held from the start.
	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	cfg_reg_t      cfg_index = REG_LOW_THRESHOLD;
	logic [SW-1:0] cfg_data = '0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [SW-1:0] sample = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic          battery_ok;
	logic          entered_error;
	logic          entered_normal;
	logic [SW-1:0] window_average;
	logic          evaluated;

	// Register copies and guard state as the model sees them.
	logic [SW-1:0]      thr_low = LOW_THRESHOLD_RST;
	logic [SW-1:0]      thr_insert = INSERT_THRESHOLD_RST;
	logic [SW-1:0]      span_limit = STABLE_SPAN_RST;
	logic [COUNT_W-1:0] recovery_reload = RECOVERY_COUNT_RST;
	logic [FILL_W-1:0]  fill_n = '0;
	logic [SUM_W-1:0]   win_sum = '0;
	logic [SW-1:0]      win_min = '0;
	logic [SW-1:0]      win_max = '0;
	logic               in_err = 1'b0;
	logic [COUNT_W-1:0] recovery_left = '0;

	sample_row_t issued_rows[$];
	guard_resp_t expected_responses[$];
	int          issued_count = 0;
	int          fail_count = 0;
	int          idle_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	// Shape of the window being generated.
	window_plan_t plan_kind = PLAN_NOISE;
	int           plan_base = 0;
	int           plan_width = 0;
	int           plan_half = 0;

	battery_undervoltage_guard #(.WINDOW(WIN)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.battery_ok(battery_ok),
		.entered_error(entered_error),
		.entered_normal(entered_normal),
		.window_average(window_average),
		.evaluated(evaluated)
	);

	always #5 clk = ~clk;

	// Advances the guard model by one accepted request and returns the response
	// it must produce. A request that finds the window full ignores its sample
	// and judges the window: a low average reloads the countdown and, if the
	// window is stable, trips a healthy battery; a high stable window in error
	// counts down, and reaching zero restores normal. An average equal to the
	// low threshold falls through both branches.
	task automatic predict_guard_response(input logic [SW-1:0] s, output guard_resp_t r);
		logic [SW-1:0] avg;
		logic          stable;
		r = '0;
		if (fill_n >= WIN) begin
			fill_n = '0;
			avg = SW'(win_sum / WIN);
			stable = (win_max - win_min) < span_limit;
			if (avg < thr_low) begin
				recovery_left = recovery_reload;
				if (!in_err && stable) begin
					in_err = 1'b1;
					r.entered_error = 1'b1;
				end
			end else if (avg > thr_low) begin
				if (in_err && avg > thr_insert && stable && recovery_left != 0) begin
					recovery_left = recovery_left - 1'b1;
					if (recovery_left == 0) begin
						in_err = 1'b0;
						r.entered_normal = 1'b1;
					end
				end
			end
			win_sum = '0;
			win_min = '0;
			win_max = '0;
			r.window_average = avg;
			r.evaluated = 1'b1;
		end else begin
			if (fill_n == 0) begin
				win_sum = SUM_W'(s);
				win_min = s;
				win_max = s;
			end else begin
				win_sum = win_sum + SUM_W'(s);
				if (s < win_min) win_min = s;
				if (s > win_max) win_max = s;
			end
			fill_n = fill_n + 1'b1;
		end
		r.battery_ok = !in_err;
	endtask

	// Both channels are observed here at the rising edge. The model advances on
	// every accepted request; a hand-typed response, when the row has one, takes
	// the place of the predicted one in the queue of expected responses.
	always @(posedge clk) begin : monitor
		sample_row_t row;
		guard_resp_t predicted;
		guard_resp_t got;
		if (in_valid && in_ready) begin
			row = issued_rows.pop_front();
			predict_guard_response(sample, predicted);
			expected_responses.push_back(row.typed ? row.resp : predicted);
		end
		if (out_valid && out_ready) begin
			got = '{battery_ok, entered_error, entered_normal, window_average, evaluated};
			if (expected_responses.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: response with nothing expected: ok=%0b err=%0b norm=%0b avg=%0d eval=%0b",
						$realtime, got.battery_ok, got.entered_error, got.entered_normal,
						got.window_average, got.evaluated);
			end else begin
				predicted = expected_responses.pop_front();
				if (got !== predicted) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: mismatch ok %0b/%0b err %0b/%0b norm %0b/%0b avg %0d/%0d eval %0b/%0b (expected/actual)",
							$realtime, predicted.battery_ok, got.battery_ok,
							predicted.entered_error, got.entered_error,
							predicted.entered_normal, got.entered_normal,
							predicted.window_average, got.window_average,
							predicted.evaluated, got.evaluated);
				end
			end
		end
	end

	// The watchdog only counts cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// The receiver decides each cycle, on the falling edge, whether to stall.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic bit sender_idles();
		return $urandom_range(0, 99) < send_idle_pct;
	endfunction

	// Presents one request and returns at the falling edge after it is taken.
	// Valid is only lowered when the sender actually idles, so back-to-back
	// requests keep it high without a glitch.
	task automatic issue_sample(input sample_row_t row);
		if (sender_idles()) begin
			in_valid <= 1'b0;
			do @(negedge clk); while (sender_idles());
		end
		issued_rows.push_back(row);
		issued_count++;
		in_valid <= 1'b1;
		sample <= row.adc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [SW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_LOW_THRESHOLD: thr_low = val;
			REG_INSERT_THRESHOLD: thr_insert = val;
			REG_STABLE_SPAN: span_limit = val;
			REG_RECOVERY_COUNT: recovery_reload = val[COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Stops the sender, lets every outstanding response drain, then loads a new
	// register setting while the block is idle.
	task automatic enter_phase(input int low, input int ins, input int span,
			input int rec, input idle_mode_t mode);
		in_valid <= 1'b0;
		while (expected_responses.size() != 0 || issued_rows.size() != 0) @(negedge clk);
		write_reg(REG_LOW_THRESHOLD, SW'(low));
		write_reg(REG_INSERT_THRESHOLD, SW'(ins));
		write_reg(REG_STABLE_SPAN, SW'(span));
		write_reg(REG_RECOVERY_COUNT, SW'(rec));
		cfg_we <= 1'b0;
		send_idle_pct = (mode == IDLE_SENDER) ? 69 : (mode == IDLE_BOTH) ? 9 : 0;
		recv_stall_pct = (mode == IDLE_RECEIVER) ? 69 : (mode == IDLE_BOTH) ? 9 : 0;
	endtask

	// Picks the shape of the next window around the current thresholds. While
	// the model is in error the mix leans toward high stable windows, so that
	// the recovery countdown gets a real chance to run out.
	task automatic plan_window();
		int roll;
		int lo;
		int hi;
		roll = $urandom_range(0, 99);
		lo = thr_low;
		hi = thr_insert;
		if ($urandom_range(0, 4) != 0)
			plan_width = (span_limit == 0) ? 0 : $urandom_range(0, span_limit - 1);
		else
			plan_width = span_limit + $urandom_range(0, 600);
		if (plan_width > 4095) plan_width = 4095;
		if (in_err) begin
			if (roll < 10) plan_kind = PLAN_BELOW;
			else if (roll < 20) plan_kind = PLAN_EQUAL;
			else if (roll < 30) plan_kind = PLAN_BETWEEN;
			else if (roll < 40) plan_kind = PLAN_NOISE;
			else plan_kind = PLAN_ABOVE;
		end else begin
			if (roll < 35) plan_kind = PLAN_BELOW;
			else if (roll < 50) plan_kind = PLAN_EQUAL;
			else if (roll < 65) plan_kind = PLAN_BETWEEN;
			else if (roll < 75) plan_kind = PLAN_NOISE;
			else plan_kind = PLAN_ABOVE;
		end
		case (plan_kind)
			PLAN_BELOW: plan_base = lo - int'($urandom_range(1, 300));
			PLAN_ABOVE: plan_base = hi + int'($urandom_range(1, 300)) + plan_width / 2;
			PLAN_BETWEEN: plan_base = (lo <= hi) ? int'($urandom_range(lo, hi)) : lo;
			default: plan_base = lo;
		endcase
		// An equal window alternates symmetrically around the low threshold so
		// the average lands on it exactly.
		plan_half = plan_width / 2;
		if (plan_half > lo) plan_half = lo;
		if (plan_half > 4095 - lo) plan_half = 4095 - lo;
	endtask

	task automatic next_random_sample(output logic [SW-1:0] s);
		int pos;
		int v;
		pos = issued_count % (WIN + 1);
		if (pos == WIN) begin
			v = $urandom_range(0, 4095);
		end else begin
			if (pos == 0) plan_window();
			case (plan_kind)
				PLAN_NOISE: v = $urandom_range(0, 4095);
				PLAN_EQUAL: v = (pos % 2 == 0) ? plan_base - plan_half : plan_base + plan_half;
				default: v = plan_base - plan_width / 2 + int'($urandom_range(0, plan_width));
			endcase
		end
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		s = v[SW-1:0];
	endtask

	initial begin : stimulus
		sample_row_t row;
		logic [SW-1:0] s;
		int low;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) issue_sample(DIRECTED[i]);

		// Register settings per phase. Recovery counts are written with junk in
		// the upper data bits, which the block must drop.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: enter_phase(2500, 2600, 64, 12'h402, IDLE_NONE);
				1: enter_phase(1000, 3000, 200, 12'hF03, IDLE_SENDER);
				// Lowest trip and highest recovery thresholds: neither can fire.
				2: enter_phase(0, 4095, 4095, 12'hFFF, IDLE_RECEIVER);
				// A zero span never counts a window as stable.
				3: enter_phase(4095, 0, 0, 12'h005, IDLE_BOTH);
				// A zero reload leaves a tripped battery in error for good.
				4: enter_phase(3000, 3100, 4095, 12'h000, IDLE_NONE);
				5: enter_phase(2048, 2048, 1, 12'h801, IDLE_SENDER);
				default: begin
					low = $urandom_range(200, 3800);
					enter_phase(low, low + int'($urandom_range(0, 200)),
						$urandom_range(0, 400),
						{4'($urandom_range(0, 15)), 8'($urandom_range(1, 6))},
						(p == 6) ? IDLE_RECEIVER : IDLE_BOTH);
				end
			endcase
			repeat (PHASE_ITEMS) begin
				next_random_sample(s);
				row.adc = s;
				row.typed = 1'b0;
				row.resp = '0;
				issue_sample(row);
			end
		end

		in_valid <= 1'b0;
		while (expected_responses.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		fail_count += expected_responses.size();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/buvg_pkg.sv
hdl/battery_undervoltage_guard.sv
tb/tb_top.sv
